>>> src/assert_macros.svh
// Assertion macros used by the checker file cle_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle property on clk, held off while rst_n is low
`define CHK_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent this cycle implies consequent on the next clk edge
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/cle_pkg.sv
// Shared types and character constants of the console line editor.
package cle_pkg;

  // Control and special characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_CTRL_D = 8'h04;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_CTRL_P = 8'h10;
  localparam logic [7:0] CH_CTRL_U = 8'h15;
  localparam logic [7:0] CH_DEL    = 8'h7f;

  // Largest erase reported in one result
  localparam int ERASE_CHUNK = 128;

  typedef enum logic [1:0] {
    KIND_ECHO  = 2'd0,
    KIND_ERASE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CLS_IGNORE,
    CLS_KILL,
    CLS_ERASE,
    CLS_STORE
  } chr_cls_t;

  // Datapath operations issued by the controller, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_ECHO,
    OP_BACKSPACE,
    OP_EMPTY,
    OP_KILL_START,
    OP_KILL_STEP,
    OP_KILL_EMIT,
    OP_RD_START,
    OP_RD_TAKE,
    OP_RD_TAKE_LAST,
    OP_PEND_MORE,
    OP_PEND_LAST,
    OP_RD_EOF
  } op_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic     req_read;
    chr_cls_t cls;
    logic     edit_at_commit;
    logic     has_room;
    logic     rd_none;
    logic     q_is_lf;
    logic     q_is_eot;
    logic     prev_at_commit;
    logic     count_zero;
    logic     chunk_last;
    logic     pend_valid;
    logic     rd_final;
    logic     out_free;
  } cle_status_t;

endpackage

>>> src/cle_dp.sv
// Datapath: line store, buffer indices, read and erase counters, result register.
module cle_dp #(
  parameter int BUFFER_DEPTH = 128,
  parameter int MAX_READ     = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_req_type,
  input  logic [7:0]           in_rx_char,
  input  logic [6:0]           in_read_len,
  input  cle_pkg::op_t         op,
  output cle_pkg::cle_status_t status,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_kind,
  output logic [7:0]           out_data,
  output logic [7:0]           out_erase_count,
  output logic                 out_line_ready,
  output logic                 out_last
);
  import cle_pkg::*;

  localparam int WRAP = 2 * BUFFER_DEPTH;
  localparam int IW   = $clog2(WRAP);
  localparam int SW   = $clog2(BUFFER_DEPTH);
  localparam int CW   = $clog2(BUFFER_DEPTH + 1);
  localparam int GW   = $clog2(MAX_READ + 1);
  localparam int XW   = CW + 8;
  localparam logic [IW-1:0] IDX_LAST  = IW'(WRAP - 1);
  localparam logic [IW-1:0] IDX_DEPTH = IW'(BUFFER_DEPTH);

  // Index helpers, indices count modulo twice the depth
  function automatic logic [IW-1:0] idx_next(logic [IW-1:0] v);
    return (v == IDX_LAST) ? '0 : v + IW'(1);
  endfunction

  function automatic logic [IW-1:0] idx_prev(logic [IW-1:0] v);
    return (v == '0) ? IDX_LAST : v - IW'(1);
  endfunction

  function automatic logic [SW-1:0] idx_slot(logic [IW-1:0] v);
    return (v >= IDX_DEPTH) ? SW'(v - IDX_DEPTH) : SW'(v);
  endfunction

  function automatic logic [IW-1:0] idx_fill(logic [IW-1:0] hi, logic [IW-1:0] lo);
    logic [IW:0] wrapped;
    wrapped = {1'b0, hi} + (IW+1)'(WRAP) - {1'b0, lo};
    return (hi >= lo) ? (hi - lo) : wrapped[IW-1:0];
  endfunction

  function automatic chr_cls_t classify(logic [7:0] c);
    chr_cls_t cls;
    if (c == CH_NUL || c == CH_CTRL_P) begin
      cls = CLS_IGNORE;
    end else if (c == CH_CTRL_U) begin
      cls = CLS_KILL;
    end else if (c == CH_BS || c == CH_DEL) begin
      cls = CLS_ERASE;
    end else begin
      cls = CLS_STORE;
    end
    return cls;
  endfunction

  logic [7:0] store_mem [BUFFER_DEPTH];
  logic [7:0] mem_q;

  logic [IW-1:0] read_idx_r, read_idx_nxt;
  logic [IW-1:0] commit_idx_r, commit_idx_nxt;
  logic [IW-1:0] edit_idx_r, edit_idx_nxt;
  logic          req_r, req_nxt;
  logic [7:0]    char_r, char_nxt;
  logic [GW-1:0] limit_r, limit_nxt;
  logic [GW-1:0] got_r, got_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          pend_valid_r, pend_valid_nxt;
  logic [7:0]    pend_data_r, pend_data_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_kind_r, out_kind_nxt;
  logic [7:0]    out_data_r, out_data_nxt;
  logic [7:0]    out_erase_r, out_erase_nxt;
  logic          out_ready_r, out_ready_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_load;

  logic          rd_en;
  logic [SW-1:0] rd_addr;
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  logic [7:0]    wr_data;

  logic [IW-1:0] edit_prev, edit_prev2, edit_next, read_next;
  logic [7:0]    store_char;
  logic          commit_now;
  logic [GW-1:0] len_limit;
  logic [GW-1:0] got_inc;
  logic [XW-1:0] count_ext;
  logic [7:0]    part;

  // Neighbor indices and derived values
  assign edit_prev  = idx_prev(edit_idx_r);
  assign edit_prev2 = idx_prev(edit_prev);
  assign edit_next  = idx_next(edit_idx_r);
  assign read_next  = idx_next(read_idx_r);
  assign store_char = (char_r == CH_CR) ? CH_LF : char_r;
  assign commit_now = (store_char == CH_LF) || (store_char == CH_CTRL_D) ||
                      (idx_fill(edit_next, read_idx_r) == IDX_DEPTH);
  assign len_limit  = (in_read_len > 7'(MAX_READ)) ? GW'(MAX_READ) : GW'(in_read_len);
  assign got_inc    = got_r + GW'(1);
  assign count_ext  = XW'(count_r);
  assign part       = (count_ext > XW'(ERASE_CHUNK)) ? 8'(ERASE_CHUNK) : 8'(count_ext);

  // Status toward the controller
  always_comb begin
    status.req_read       = req_r;
    status.cls            = classify(char_r);
    status.edit_at_commit = (edit_idx_r == commit_idx_r);
    status.has_room       = (idx_fill(edit_idx_r, read_idx_r) < IDX_DEPTH);
    status.rd_none        = (limit_r == '0) || (read_idx_r == commit_idx_r);
    status.q_is_lf        = (mem_q == CH_LF);
    status.q_is_eot       = (mem_q == CH_CTRL_D);
    status.prev_at_commit = (edit_prev == commit_idx_r);
    status.count_zero     = (count_r == '0);
    status.chunk_last     = (count_ext <= XW'(ERASE_CHUNK));
    status.pend_valid     = pend_valid_r;
    status.rd_final       = (mem_q == CH_LF) || (got_inc == limit_r) ||
                            (read_next == commit_idx_r);
    status.out_free       = !out_valid_r || !out_stall;
  end

  // Operation decode
  always_comb begin
    read_idx_nxt   = read_idx_r;
    commit_idx_nxt = commit_idx_r;
    edit_idx_nxt   = edit_idx_r;
    req_nxt        = req_r;
    char_nxt       = char_r;
    limit_nxt      = limit_r;
    got_nxt        = got_r;
    count_nxt      = count_r;
    pend_valid_nxt = pend_valid_r;
    pend_data_nxt  = pend_data_r;
    out_load       = 1'b0;
    out_kind_nxt   = KIND_NONE;
    out_data_nxt   = 8'd0;
    out_erase_nxt  = 8'd0;
    out_ready_nxt  = 1'b0;
    out_last_nxt   = 1'b1;
    rd_en          = 1'b0;
    rd_addr        = idx_slot(read_idx_r);
    wr_en          = 1'b0;
    wr_addr        = idx_slot(edit_idx_r);
    wr_data        = store_char;
    case (op)
      OP_LATCH: begin
        req_nxt   = in_req_type;
        char_nxt  = in_rx_char;
        limit_nxt = len_limit;
      end
      OP_ECHO: begin
        wr_en         = 1'b1;
        edit_idx_nxt  = edit_next;
        if (commit_now) begin
          commit_idx_nxt = edit_next;
        end
        out_load      = 1'b1;
        out_kind_nxt  = KIND_ECHO;
        out_data_nxt  = store_char;
        out_ready_nxt = commit_now;
      end
      OP_BACKSPACE: begin
        edit_idx_nxt  = edit_prev;
        out_load      = 1'b1;
        out_kind_nxt  = KIND_ERASE;
        out_erase_nxt = 8'd1;
      end
      OP_EMPTY: begin
        out_load = 1'b1;
      end
      OP_KILL_START: begin
        rd_en     = 1'b1;
        rd_addr   = idx_slot(edit_prev);
        count_nxt = '0;
      end
      OP_KILL_STEP: begin
        // mem_q holds the byte just before the edit point
        if (mem_q != CH_LF) begin
          edit_idx_nxt = edit_prev;
          count_nxt    = count_r + CW'(1);
          rd_en        = 1'b1;
          rd_addr      = idx_slot(edit_prev2);
        end
      end
      OP_KILL_EMIT: begin
        out_load      = 1'b1;
        out_kind_nxt  = KIND_ERASE;
        out_erase_nxt = part;
        out_last_nxt  = status.chunk_last;
        count_nxt     = CW'(count_ext - XW'(part));
      end
      OP_RD_START: begin
        rd_en          = 1'b1;
        got_nxt        = '0;
        pend_valid_nxt = 1'b0;
      end
      OP_RD_TAKE: begin
        // hold the byte until the next one shows whether it ends the read
        pend_data_nxt  = mem_q;
        pend_valid_nxt = 1'b1;
        read_idx_nxt   = read_next;
        got_nxt        = got_inc;
        rd_en          = 1'b1;
        rd_addr        = idx_slot(read_next);
      end
      OP_RD_TAKE_LAST: begin
        read_idx_nxt = read_next;
        out_load     = 1'b1;
        out_kind_nxt = KIND_READ;
        out_data_nxt = mem_q;
      end
      OP_PEND_MORE: begin
        pend_valid_nxt = 1'b0;
        out_load       = 1'b1;
        out_kind_nxt   = KIND_READ;
        out_data_nxt   = pend_data_r;
        out_last_nxt   = 1'b0;
      end
      OP_PEND_LAST: begin
        pend_valid_nxt = 1'b0;
        out_load       = 1'b1;
        out_kind_nxt   = KIND_READ;
        out_data_nxt   = pend_data_r;
      end
      OP_RD_EOF: begin
        // end of file at the head of the read: consume it
        read_idx_nxt = read_next;
        out_load     = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  // Line store, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= store_mem[rd_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_idx_r   <= '0;
      commit_idx_r <= '0;
      edit_idx_r   <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      read_idx_r   <= read_idx_nxt;
      commit_idx_r <= commit_idx_nxt;
      edit_idx_r   <= edit_idx_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    char_r      <= char_nxt;
    limit_r     <= limit_nxt;
    got_r       <= got_nxt;
    count_r     <= count_nxt;
    pend_data_r <= pend_data_nxt;
    if (out_load) begin
      out_kind_r  <= out_kind_nxt;
      out_data_r  <= out_data_nxt;
      out_erase_r <= out_erase_nxt;
      out_ready_r <= out_ready_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_data        = out_data_r;
  assign out_erase_count = out_erase_r;
  assign out_line_ready  = out_ready_r;
  assign out_last        = out_last_r;

endmodule

>>> src/cle_ctrl.sv
// Controller: state machine that sequences edit, kill and read operations.
module cle_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cle_pkg::cle_status_t status,
  output cle_pkg::op_t         op
);
  import cle_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_DECODE  = 5'b00010,
    ST_KILL    = 5'b00100,
    ST_KEMIT   = 5'b01000,
    ST_RD_LOOK = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  // Next state and operation
  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op        = OP_LATCH;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status.req_read) begin
          if (status.rd_none) begin
            if (status.out_free) begin
              op        = OP_EMPTY;
              state_nxt = ST_IDLE;
            end
          end else begin
            op        = OP_RD_START;
            state_nxt = ST_RD_LOOK;
          end
        end else begin
          case (status.cls)
            CLS_IGNORE: state_nxt = ST_IDLE;
            CLS_KILL: begin
              if (status.edit_at_commit) begin
                state_nxt = ST_IDLE;
              end else begin
                op        = OP_KILL_START;
                state_nxt = ST_KILL;
              end
            end
            CLS_ERASE: begin
              if (status.edit_at_commit) begin
                state_nxt = ST_IDLE;
              end else if (status.out_free) begin
                op        = OP_BACKSPACE;
                state_nxt = ST_IDLE;
              end
            end
            CLS_STORE: begin
              if (!status.has_room) begin
                state_nxt = ST_IDLE;
              end else if (status.out_free) begin
                op        = OP_ECHO;
                state_nxt = ST_IDLE;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_KILL: begin
        // walk back one entry a cycle until a newline or the commit point
        op = OP_KILL_STEP;
        if (status.q_is_lf || status.prev_at_commit) begin
          state_nxt = ST_KEMIT;
        end
      end
      ST_KEMIT: begin
        if (status.count_zero) begin
          state_nxt = ST_IDLE;
        end else if (status.out_free) begin
          op = OP_KILL_EMIT;
          if (status.chunk_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_RD_LOOK: begin
        if (status.pend_valid) begin
          if (status.out_free) begin
            if (status.q_is_eot) begin
              op        = OP_PEND_LAST;
              state_nxt = ST_IDLE;
            end else begin
              op = OP_PEND_MORE;
            end
          end
        end else if (status.q_is_eot) begin
          if (status.out_free) begin
            op        = OP_RD_EOF;
            state_nxt = ST_IDLE;
          end
        end else if (status.rd_final) begin
          if (status.out_free) begin
            op        = OP_RD_TAKE_LAST;
            state_nxt = ST_IDLE;
          end
        end else begin
          op = OP_RD_TAKE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/console_line_editor_core.sv
// Top level of the console line editor: controller plus datapath.
// One request is worked at a time. A received byte is accepted, then acted on;
// a Control-U walks back over the bytes to erase until a newline or the commit
// point, then reports the erase in results of up to 128 characters each; in a read,
// each byte costs one registered read of the line store's read port and a
// step to hand it to the result register. The next request is accepted once the
// last result of the previous one sits in the result register, or once a request
// that yields no result is decoded. The line store is not cleared after reset;
// only bytes already written are ever read back.
module console_line_editor_core #(
  parameter int BUFFER_DEPTH = 128,
  parameter int MAX_READ     = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_req_type,
  input  logic [7:0] in_rx_char,
  input  logic [6:0] in_read_len,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_data,
  output logic [7:0] out_erase_count,
  output logic       out_line_ready,
  output logic       out_last
);
  import cle_pkg::*;

  op_t         op;
  cle_status_t status;

  // Sequencer
  cle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .op       (op)
  );

  // Store, indices and result register
  cle_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .MAX_READ     (MAX_READ)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_req_type     (in_req_type),
    .in_rx_char      (in_rx_char),
    .in_read_len     (in_read_len),
    .op              (op),
    .status          (status),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_data        (out_data),
    .out_erase_count (out_erase_count),
    .out_line_ready  (out_line_ready),
    .out_last        (out_last)
  );

endmodule

>>> src/cle_checker.sv
// Port-level checks on the line editor's result channel, bound to the top level.
`include "assert_macros.svh"

module cle_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_kind,
  input logic [7:0] out_data,
  input logic [7:0] out_erase_count,
  input logic       out_line_ready,
  input logic       out_last
);
  import cle_pkg::*;

  // A committed line is flagged only on a single echo result
  `CHK_PROP(a_ready_echo, out_valid && out_line_ready |-> out_kind == KIND_ECHO && out_last, "line_ready on a non-echo result")

  // Erase results carry a count and no byte
  `CHK_PROP(a_erase_shape, out_valid && out_kind == KIND_ERASE |-> out_erase_count != 8'd0 && out_data == 8'd0, "bad erase result")

  // An empty read is a single, final, blank result
  `CHK_PROP(a_empty_read, out_valid && out_kind == KIND_NONE |-> out_last && out_data == 8'd0 && out_erase_count == 8'd0, "bad empty-read result")

  // A stalled result stays put
  `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_kind) && $stable(out_data) && $stable(out_last), "result changed under stall")

endmodule

bind console_line_editor_core cle_checker u_cle_checker (.*);

>>> tb/sv/console_line_editor_check.sv
// Checker for the console line editor: tracks the line buffer, predicts results, compares.
`timescale 1ns / 1ps

module console_line_editor_check (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_req_type,
  input  logic [7:0] in_rx_char,
  input  logic [6:0] in_read_len,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] out_kind,
  input  logic [7:0] out_data,
  input  logic [7:0] out_erase_count,
  input  logic       out_line_ready,
  input  logic       out_last,
  output int         mismatches,
  output int         results_waiting
);
  import cle_pkg::*;

  localparam int MAX_READ = 64;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] erase;
    logic       ready;
    logic       last;
  } line_result_t;

  // Shadow of the line buffer; pointers count modulo twice the depth
  logic [7:0]   line_mem [0:127];
  logic [7:0]   read_ptr = 8'd0;
  logic [7:0]   commit_ptr = 8'd0;
  logic [7:0]   edit_ptr = 8'd0;

  line_result_t results_due [$];
  line_result_t want;
  int           miss_count = 0;
  int           due_count = 0;

  assign mismatches      = miss_count;
  assign results_waiting = due_count;

  function automatic void add_result(input kind_t k, input logic [7:0] d,
                                     input logic [7:0] e, input logic rdy);
    line_result_t r;
    r.kind  = k;
    r.data  = d;
    r.erase = e;
    r.ready = rdy;
    r.last  = 1'b0;
    results_due.push_back(r);
  endfunction

  // Apply one request to the shadow buffer and queue what it should produce
  task automatic edit_and_read(input logic rt, input logic [7:0] ch, input logic [6:0] len);
    int           first;
    int           erased;
    int           part;
    int           lim;
    int           got;
    logic [7:0]   c;
    logic [7:0]   b;
    logic [7:0]   back;
    logic [7:0]   fill;
    logic         ready;
    line_result_t r;
    first = results_due.size();
    c = ch;
    if (!rt) begin
      fill = edit_ptr - read_ptr;
      if (c == CH_CTRL_P || c == CH_NUL) begin
        // dropped silently
      end else if (c == CH_CTRL_U) begin
        // walk back to the commit point or the previous newline
        erased = 0;
        back = edit_ptr - 8'd1;
        while (edit_ptr != commit_ptr && line_mem[back[6:0]] != CH_LF) begin
          edit_ptr = back;
          back = edit_ptr - 8'd1;
          erased++;
        end
        while (erased > 0) begin
          part = (erased > ERASE_CHUNK) ? ERASE_CHUNK : erased;
          add_result(KIND_ERASE, 8'h00, 8'(part), 1'b0);
          erased -= part;
        end
      end else if (c == CH_BS || c == CH_DEL) begin
        if (edit_ptr != commit_ptr) begin
          edit_ptr = edit_ptr - 8'd1;
          add_result(KIND_ERASE, 8'h00, 8'd1, 1'b0);
        end
      end else if (fill < 8'd128) begin
        // store and echo; newline, EOF or a full buffer commits
        if (c == CH_CR) c = CH_LF;
        line_mem[edit_ptr[6:0]] = c;
        edit_ptr = edit_ptr + 8'd1;
        fill = edit_ptr - read_ptr;
        ready = (c == CH_LF || c == CH_CTRL_D || fill == 8'd128);
        if (ready) commit_ptr = edit_ptr;
        add_result(KIND_ECHO, c, 8'h00, ready);
      end
    end else begin
      // non-blocking read of committed bytes, up to one line
      lim = (int'(len) > MAX_READ) ? MAX_READ : int'(len);
      got = 0;
      while (got < lim && read_ptr != commit_ptr) begin
        b = line_mem[read_ptr[6:0]];
        if (b == CH_CTRL_D) begin
          // EOF is consumed only at the head of a read
          if (got == 0) read_ptr = read_ptr + 8'd1;
          break;
        end
        read_ptr = read_ptr + 8'd1;
        add_result(KIND_READ, b, 8'h00, 1'b0);
        got++;
        if (b == CH_LF) break;
      end
      if (got == 0) add_result(KIND_NONE, 8'h00, 8'h00, 1'b0);
    end
    if (results_due.size() > first) begin
      r = results_due.pop_back();
      r.last = 1'b1;
      results_due.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, name, exp_v, got_v);
      miss_count++;
    end
  endtask

  // Track requests in, compare results out
  always @(posedge clk) begin
    if (!rst_n) begin
      read_ptr   = 8'd0;
      commit_ptr = 8'd0;
      edit_ptr   = 8'd0;
      results_due.delete();
    end else begin
      if (in_valid && !in_stall) edit_and_read(in_req_type, in_rx_char, in_read_len);
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $display("%0t ns: expected no result, got kind %0d data %0h erase %0d ready %0b last %0b",
                   $time, out_kind, out_data, out_erase_count, out_line_ready, out_last);
          miss_count++;
        end else begin
          want = results_due.pop_front();
          check_field("kind", want.kind, out_kind);
          check_field("data", want.data, out_data);
          check_field("erase_count", want.erase, out_erase_count);
          check_field("line_ready", want.ready, out_line_ready);
          check_field("last", want.last, out_last);
        end
      end
    end
    due_count <= results_due.size();
  end

endmodule

>>> tb/sv/console_line_editor_core_tb.sv
// Top of the console line editor testbench: clock, reset, request traffic and verdict.
`timescale 1ns / 1ps

module console_line_editor_core_tb;
  import cle_pkg::*;

  localparam int          RAND_ITEMS   = 410;
  localparam int          HOLD_AT      = 150;
  localparam int          PAUSE_AT     = 250;
  localparam int          QUIET_AT     = 350;
  localparam int          LONG_HOLD    = 400;
  localparam int          DRAIN_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT  = 3000000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_req_type;
  logic [7:0] in_rx_char;
  logic [6:0] in_read_len;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_kind;
  logic [7:0] out_data;
  logic [7:0] out_erase_count;
  logic       out_line_ready;
  logic       out_last;

  int          mismatches;
  int          results_waiting;
  int          n_sent;
  bit          quiet;
  bit          hold_ask;
  int unsigned cycle_cnt;

  console_line_editor_core uut (.*);

  console_line_editor_check check (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offer one request and hold it until taken; maybe idle afterwards
  task automatic send_req(input logic rt, input logic [7:0] ch, input logic [6:0] len);
    in_valid    <= 1'b1;
    in_req_type <= rt;
    in_rx_char  <= ch;
    in_read_len <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (rt || (ch != CH_NUL && ch != CH_CTRL_P)) n_sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic type_char(input logic [7:0] ch);
    send_req(1'b0, ch, 7'($urandom_range(0, 127)));
  endtask

  task automatic read_line(input logic [6:0] len);
    send_req(1'b1, 8'($urandom_range(0, 255)), len);
  endtask

  // Mostly legal lengths, sometimes zero or above the read cap
  function automatic logic [6:0] pick_read_len();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 7'd0;
    if (p == 1) return 7'($urandom_range(65, 127));
    return 7'($urandom_range(1, 64));
  endfunction

  // Printable text with occasional backspace, DEL and line kill
  task automatic type_line(input int n);
    int e;
    repeat (n) begin
      e = $urandom_range(0, 39);
      if (e < 3) type_char(CH_BS);
      else if (e < 5) type_char(CH_DEL);
      else if (e == 5) type_char(CH_CTRL_U);
      else type_char(8'($urandom_range(32, 126)));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_waiting != 0);
  endtask

  // Result side backpressure
  initial begin
    bit held;
    bit stall_v;
    int span;
    held = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_ask && !held) begin
        // long hold so the block backs up into its input
        held    = 1'b1;
        stall_v = 1'b1;
        span    = LONG_HOLD;
      end else if (quiet) begin
        stall_v = 1'b0;
        span    = 1;
      end else begin
        stall_v = ($urandom_range(0, 2) == 0);
        span    = $urandom_range(1, 15);
        if (!stall_v && $urandom_range(0, 7) == 0) span = $urandom_range(40, 120);
      end
      out_stall <= stall_v;
      repeat (span) @(posedge clk);
    end
  end

  // Run limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Request traffic and verdict
  initial begin
    bit paused;
    int pick;
    in_valid    <= 1'b0;
    in_req_type <= 1'b0;
    in_rx_char  <= 8'h00;
    in_read_len <= 7'd0;
    rst_n       <= 1'b0;
    quiet       <= 1'b0;
    hold_ask    <= 1'b0;
    paused = 1'b0;
    n_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty buffer: read, erase and kill have nothing to work on
    read_line(7'd8);
    type_char(CH_BS);
    type_char(CH_CTRL_U);
    type_char(CH_CTRL_P);
    type_char(CH_NUL);
    // Edit a line, CR becomes LF and commits
    type_char("a");
    type_char("b");
    type_char(CH_BS);
    type_char(CH_DEL);
    type_char("c");
    type_char(CH_CR);
    read_line(7'd0);
    read_line(7'd127);
    // Kill the open line
    type_char("x");
    type_char("y");
    type_char(CH_CTRL_U);
    // EOF at the head of a read, then after data
    type_char(CH_CTRL_D);
    read_line(7'd5);
    type_char("q");
    type_char(CH_CTRL_D);
    read_line(7'd64);
    read_line(7'd1);
    // All-ones byte, single byte reads
    type_char(8'hff);
    type_char(CH_LF);
    read_line(7'd1);
    read_line(7'd64);

    n_sent = 0;
    while (n_sent < RAND_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        // long line: may fill the buffer, ends in a kill or a newline
        type_line($urandom_range(70, 135));
        type_char($urandom_range(0, 1) ? CH_CTRL_U : CH_LF);
        repeat ($urandom_range(3, 6)) read_line(7'd64);
      end else if (pick < 5) begin
        // raw noise
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1)) read_line(7'($urandom_range(0, 127)));
          else type_char(8'($urandom_range(0, 255)));
        end
      end else begin
        type_line($urandom_range(0, 24));
        case ($urandom_range(0, 5))
          0: type_char(CH_CR);
          1: type_char(CH_CTRL_D);
          2: ;
          default: type_char(CH_LF);
        endcase
        repeat ($urandom_range(1, 3)) read_line(pick_read_len());
      end
      if (n_sent >= HOLD_AT) hold_ask <= 1'b1;
      if (n_sent >= QUIET_AT) quiet <= 1'b1;
      if (!paused && n_sent >= PAUSE_AT) begin
        paused = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (results_waiting != 0)
      $display("%0t ns: %0d expected results never arrived", $time, results_waiting);
    if (mismatches == 0 && results_waiting == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
